>>> sv/kvmt_pkg.sv
// ----------------------------------------------------------------------------
// kvmt_pkg: shared types and codes of the key/value map table
// Holds the request and status codes, the controller state type and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package kvmt_pkg;

   localparam int unsigned KEY_W    = 64;
   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned STATUS_W = 2;

   // Request codes.
   localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ERASE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

   // One row of the key memory.
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
   } kvmt_kent_type;

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCAN   = 6'b000100,
      S_DRAIN  = 6'b001000,
      S_APPLY  = 6'b010000,
      S_FINISH = 6'b100000
   } kvmt_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic cnt_inc;
      logic clear_wr;
      logic scan_rd;
      logic apply;
      logic load_rsp;
   } kvmt_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_last;
      logic rsp_busy;
   } kvmt_stat_type;

endpackage

>>> sv/kvmt_datapath.sv
// ----------------------------------------------------------------------------
// kvmt_datapath: storage, scan compare and result register
// Key and value memories, the slot counter, the per-item match and free-slot
// trackers, and the output word register.
// ----------------------------------------------------------------------------
module kvmt_datapath #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  kvmt_pkg::kvmt_cmd_type                 cmd,
   output kvmt_pkg::kvmt_stat_type                stat,
   input  logic [kvmt_pkg::ACTION_W-1:0]          req_action,
   input  logic [kvmt_pkg::KEY_W-1:0]             req_key,
   input  logic [kvmt_pkg::VALUE_W-1:0]           req_value,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [kvmt_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_found,
   output logic [kvmt_pkg::VALUE_W-1:0]           rsp_read_value
);
   import kvmt_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   kvmt_kent_type          kmem [ENTRIES];
   logic [VALUE_W-1:0]     vmem [ENTRIES];

   logic [ACTION_W-1:0]    act_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [VALUE_W-1:0]     val_ff;
   logic [IDX_W-1:0]       cnt_ff;
   kvmt_kent_type          krd_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_vld_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic                   free_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic [VALUE_W-1:0]     vrd_ff;
   logic                   rsp_vld_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic                   found_ff;
   logic [VALUE_W-1:0]     rdval_ff;

   logic                   kwe;
   logic [IDX_W-1:0]       kwaddr;
   kvmt_kent_type          kwdata;
   logic                   vwe;
   logic [IDX_W-1:0]       vwaddr;
   logic [STATUS_W-1:0]    status_in;
   logic                   found_in;
   logic [VALUE_W-1:0]     rdval_in;

   assign stat.cnt_last = (cnt_ff == IDX_W'(ENTRIES - 1));
   assign stat.rsp_busy = rsp_vld_ff && !rsp_tready;

   // Item latch and slot counter.
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         act_ff <= req_action;
         key_ff <= req_key;
         val_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load_item) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
   end

   // Key and value memory write ports: clearing pass, insert, overwrite, or erase.
   always_comb begin
      kwe          = 1'b0;
      kwaddr       = cnt_ff;
      kwdata.valid = 1'b0;
      kwdata.key   = key_ff;
      vwe          = 1'b0;
      vwaddr       = hit_idx_ff;
      if (cmd.clear_wr) begin
         kwe = 1'b1;
      end else if (cmd.apply) begin
         case (act_ff)
            ACT_PUT: begin
               if (hit_ff) begin
                  vwe = 1'b1;
               end else if (free_ff) begin
                  kwe          = 1'b1;
                  kwaddr       = free_idx_ff;
                  kwdata.valid = 1'b1;
                  vwe          = 1'b1;
                  vwaddr       = free_idx_ff;
               end
            end
            ACT_ERASE: begin
               if (hit_ff) begin
                  kwe    = 1'b1;
                  kwaddr = hit_idx_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (kwe) begin
         kmem[kwaddr] <= kwdata;
      end
      if (cmd.scan_rd) begin
         krd_ff <= kmem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (vwe) begin
         vmem[vwaddr] <= val_ff;
      end
      if (cmd.apply) begin
         vrd_ff <= vmem[hit_idx_ff];
      end
   end

   // Compare stage, one slot per cycle, in the cycle after the read.
   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff;
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_item) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (rd_vld_ff) begin
         if (krd_ff.valid && (krd_ff.key == key_ff)) begin
            hit_ff <= 1'b1;
         end
         if (!krd_ff.valid && !free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         if (krd_ff.valid && (krd_ff.key == key_ff)) begin
            hit_idx_ff <= rd_idx_ff;
         end
         if (!krd_ff.valid && !free_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // Result word.
   always_comb begin
      status_in = STAT_OK;
      found_in  = 1'b0;
      rdval_in  = '0;
      case (act_ff)
         ACT_PUT: begin
            found_in = hit_ff;
            if (!hit_ff && !free_ff) begin
               status_in = STAT_FULL;
            end
         end
         ACT_ERASE: begin
            found_in = hit_ff;
            if (!hit_ff) begin
               status_in = STAT_NOT_FOUND;
            end
         end
         ACT_LOOKUP: begin
            found_in = hit_ff;
            if (hit_ff) begin
               rdval_in = vrd_ff;
            end else begin
               status_in = STAT_NOT_FOUND;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         rdval_ff  <= rdval_in;
      end
   end

   assign rsp_tvalid     = rsp_vld_ff;
   assign rsp_status     = status_ff;
   assign rsp_found      = found_ff;
   assign rsp_read_value = rdval_ff;

endmodule

>>> sv/kvmt_ctrl.sv
// ----------------------------------------------------------------------------
// kvmt_ctrl: sequencing state machine of the key/value map table
// Runs the clearing pass, the slot scan, the table update and the hand-off
// of each result word to the output register.
// ----------------------------------------------------------------------------
module kvmt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  kvmt_pkg::kvmt_stat_type stat,
   output kvmt_pkg::kvmt_cmd_type  cmd
);
   import kvmt_pkg::*;

   kvmt_state_type state_ff;
   kvmt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.cnt_inc = 1'b1;
            if (stat.cnt_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

>>> sv/key_value_map_table.sv
// ----------------------------------------------------------------------------
// key_value_map_table: fixed-capacity table of unique 64-bit key/value pairs
// Put, erase and lookup requests on a stream input, one result word each.
// ----------------------------------------------------------------------------
// Each request word asks for a put (insert or overwrite), an erase or a
// lookup of one key, and produces exactly one result word with a status,
// a found flag and, for a successful lookup, the stored value. A put of a
// new key goes into the lowest-numbered free slot; when no slot is free the
// table is left as it is and the result reports the table as full. The
// table is searched by scanning the key memory one slot per clock. A
// request then passes through the drain, apply and finish states before its
// result is loaded into the output register, which happens only once that
// register is empty or its word is being taken. A new request is taken as
// soon as the previous one has been handed to the output register, even
// while that result still waits for the consumer. After reset the block
// runs a clearing pass over the key memory, during which req_tready
// stays low.
// ----------------------------------------------------------------------------
module key_value_map_table #(
   parameter int unsigned ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] key, [127:64] value
   input  logic [1:0]   req_tuser,   // [1:0] action
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [63:0] read_value
   output logic [2:0]   rsp_tuser    // [1:0] status, [2] found
);
   import kvmt_pkg::*;

   kvmt_cmd_type         cmd;
   kvmt_stat_type        stat;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_found;

   // The controller only sequences; all storage and compare sits in the
   // datapath.
   kvmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   kvmt_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_tuser),
      .req_key        (req_tdata[63:0]),
      .req_value      (req_tdata[127:64]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_found      (rsp_found),
      .rsp_read_value (rsp_tdata)
   );

   assign rsp_tuser = {rsp_found, rsp_status};

endmodule
